>>> src/i2w_pkg.sv
// ----------------------------------------------------------------------------
// i2w_pkg: shared types and helpers for integer_to_word_tokens
// Word token codes, the front-to-back queue entry and digit helpers.
// ----------------------------------------------------------------------------
package i2w_pkg;

   localparam int VALUE_W     = 31;
   localparam int WORD_W      = 5;
   localparam int GROUPS      = 4;
   localparam int GROUP_W     = 10;
   localparam int HUND_W      = 4;
   localparam int REST_W      = 7;
   localparam int SLOTS       = 5;
   localparam int SLOT_W      = 3;
   localparam int GIDX_W      = 2;
   localparam int DIV_STEPS   = 3;

   // floor(x / 1000) = ((x >> 3) * RECIP_125) >> RECIP_SHIFT for 28-bit x >> 3
   localparam int QIN_W       = 28;
   localparam int RECIP_W     = 29;
   localparam int PROD_W      = QIN_W + RECIP_W;
   localparam int RECIP_SHIFT = 35;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;
   localparam logic [VALUE_W-1:0] GROUP_BASE = 31'd1000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [WORD_W-1:0] WORD_ZERO     = 5'd0;
   localparam logic [WORD_W-1:0] TENS_BASE     = 5'd18;
   localparam logic [WORD_W-1:0] WORD_HUNDRED  = 5'd28;
   localparam logic [WORD_W-1:0] WORD_THOUSAND = 5'd29;
   localparam logic [WORD_W-1:0] WORD_MILLION  = 5'd30;
   localparam logic [WORD_W-1:0] WORD_BILLION  = 5'd31;

   localparam logic [SLOT_W-1:0] SLOT_HUND_DIGIT = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_HUND_WORD  = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_TENS       = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_ONES       = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_SCALE      = 3'd4;

   localparam logic [GIDX_W-1:0] GRP_UNIT     = 2'd0;
   localparam logic [GIDX_W-1:0] GRP_THOUSAND = 2'd1;
   localparam logic [GIDX_W-1:0] GRP_MILLION  = 2'd2;
   localparam logic [GIDX_W-1:0] GRP_BILLION  = 2'd3;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_MUL,
      FS_DIV,
      FS_PUSH
   } front_state_type;

   typedef struct packed {
      logic                             zero;
      logic [GROUPS-1:0]                nz;
      logic [GROUPS-1:0][HUND_W-1:0]    hund;
      logic [GROUPS-1:0][REST_W-1:0]    rest;
   } i2w_entry_type;

   function automatic logic [HUND_W-1:0] hund_digit(input logic [GROUP_W-1:0] g);
      logic [HUND_W-1:0] h;
      h = '0;
      for (int k = 1; k < 10; k++) begin
         if (g >= GROUP_W'(k * 100)) h = HUND_W'(k);
      end
      return h;
   endfunction

   function automatic logic [REST_W-1:0] hund_rest(input logic [GROUP_W-1:0] g);
      logic [GROUP_W-1:0] p;
      p = GROUP_W'(hund_digit(g)) * GROUP_W'(100);
      return REST_W'(g - p);
   endfunction

   function automatic logic [HUND_W-1:0] tens_digit(input logic [REST_W-1:0] r);
      logic [HUND_W-1:0] t;
      t = '0;
      for (int k = 1; k < 10; k++) begin
         if (r >= REST_W'(k * 10)) t = HUND_W'(k);
      end
      return t;
   endfunction

   function automatic logic [HUND_W-1:0] tens_rest(input logic [REST_W-1:0] r);
      logic [REST_W-1:0] p;
      p = REST_W'(tens_digit(r)) * REST_W'(10);
      return HUND_W'(r - p);
   endfunction

endpackage

>>> src/i2w_front.sv
// ----------------------------------------------------------------------------
// i2w_front: value intake and group split
// Splits the value into four groups of three decimal digits, one reciprocal
// division per lower group, and hands one entry per value to the queue.
// ----------------------------------------------------------------------------
module i2w_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [i2w_pkg::VALUE_W-1:0]   req_value,
   output logic                          push_valid,
   input  logic                          push_ready,
   output i2w_pkg::i2w_entry_type        push_entry
);

   i2w_pkg::front_state_type state_ff, state_in;

   logic [i2w_pkg::VALUE_W-1:0]                     x_ff, x_in;
   logic [i2w_pkg::PROD_W-1:0]                      prod_ff, prod_in;
   logic [1:0]                                      cnt_ff, cnt_in;
   logic [i2w_pkg::GROUPS-1:0][i2w_pkg::GROUP_W-1:0] grp_ff, grp_in;

   logic                               accept;
   logic                               mul_en;
   logic                               div_en;
   logic [i2w_pkg::QUOT_W-1:0]         quot;
   logic [i2w_pkg::VALUE_W-1:0]        rem_full;
   logic                               last_div;

   assign accept   = req_valid && req_ready;
   assign quot     = prod_ff[i2w_pkg::PROD_W-1:i2w_pkg::RECIP_SHIFT];
   assign rem_full = x_ff - i2w_pkg::VALUE_W'(quot) * i2w_pkg::GROUP_BASE;
   assign last_div = (cnt_ff == 2'(i2w_pkg::DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2w_pkg::FS_IDLE: begin
            if (req_valid) state_in = i2w_pkg::FS_MUL;
         end
         i2w_pkg::FS_MUL: begin
            state_in = i2w_pkg::FS_DIV;
         end
         i2w_pkg::FS_DIV: begin
            state_in = last_div ? i2w_pkg::FS_PUSH : i2w_pkg::FS_MUL;
         end
         i2w_pkg::FS_PUSH: begin
            if (push_ready) state_in = req_valid ? i2w_pkg::FS_MUL : i2w_pkg::FS_IDLE;
         end
         default: begin
            state_in = i2w_pkg::FS_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      mul_en     = 1'b0;
      div_en     = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         i2w_pkg::FS_IDLE: begin
            req_ready = 1'b1;
         end
         i2w_pkg::FS_MUL: begin
            mul_en = 1'b1;
         end
         i2w_pkg::FS_DIV: begin
            div_en = 1'b1;
         end
         i2w_pkg::FS_PUSH: begin
            push_valid = 1'b1;
            req_ready  = push_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      x_in    = x_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      grp_in  = grp_ff;
      if (accept) begin
         x_in   = req_value;
         cnt_in = '0;
      end
      if (mul_en) begin
         prod_in = i2w_pkg::PROD_W'(x_ff[i2w_pkg::VALUE_W-1:3]) *
                   i2w_pkg::PROD_W'(i2w_pkg::RECIP_125);
      end
      if (div_en) begin
         grp_in[cnt_ff] = i2w_pkg::GROUP_W'(rem_full);
         x_in           = i2w_pkg::VALUE_W'(quot);
         cnt_in         = cnt_ff + 2'd1;
         if (last_div) grp_in[i2w_pkg::GRP_BILLION] = i2w_pkg::GROUP_W'(quot);
      end
   end

   always_comb begin
      push_entry = '0;
      for (int g = 0; g < i2w_pkg::GROUPS; g++) begin
         push_entry.nz[g]   = (grp_ff[g] != '0);
         push_entry.hund[g] = i2w_pkg::hund_digit(grp_ff[g]);
         push_entry.rest[g] = i2w_pkg::hund_rest(grp_ff[g]);
      end
      push_entry.zero = (grp_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2w_pkg::FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
      grp_ff  <= grp_in;
   end

endmodule

>>> src/i2w_queue.sv
// ----------------------------------------------------------------------------
// i2w_queue: entry queue between front and back
// Short FIFO of split values; decouples the group split from word emission.
// ----------------------------------------------------------------------------
module i2w_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  i2w_pkg::i2w_entry_type  push_entry,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output i2w_pkg::i2w_entry_type  pop_entry
);

   i2w_pkg::i2w_entry_type mem_ff [i2w_pkg::QUEUE_DEPTH];

   logic [i2w_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [i2w_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [i2w_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != i2w_pkg::QUEUE_CNT_W'(i2w_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == i2w_pkg::QUEUE_PTR_W'(i2w_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == i2w_pkg::QUEUE_PTR_W'(i2w_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= i2w_pkg::QUEUE_CNT_W'(i2w_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

>>> src/i2w_back.sv
// ----------------------------------------------------------------------------
// i2w_back: word token emission
// Walks the nonzero groups of one entry, billion first, and emits one word
// token per cycle unless the response stalls, into a registered result stage.
// ----------------------------------------------------------------------------
module i2w_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  i2w_pkg::i2w_entry_type        pop_entry,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [i2w_pkg::WORD_W-1:0]    rsp_word,
   output logic                          rsp_last
);

   logic                              busy_ff, busy_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [i2w_pkg::WORD_W-1:0]        rsp_word_ff, rsp_word_in;
   logic                              rsp_last_ff, rsp_last_in;
   i2w_pkg::i2w_entry_type            entry_ff, entry_in;
   logic [i2w_pkg::GIDX_W-1:0]        gi_ff, gi_in;
   logic [i2w_pkg::SLOT_W-1:0]        slot_ff, slot_in;

   logic [i2w_pkg::HUND_W-1:0]        h;
   logic [i2w_pkg::REST_W-1:0]        r;
   logic [i2w_pkg::HUND_W-1:0]        tens;
   logic [i2w_pkg::HUND_W-1:0]        ones;
   logic [i2w_pkg::SLOTS-1:0]         valid_slot;
   logic [i2w_pkg::SLOTS-1:0]         avail;
   logic [i2w_pkg::SLOT_W-1:0]        cur;
   logic                              found;
   logic                              more;
   logic [i2w_pkg::GROUPS-1:0]        lower_nz;
   logic [i2w_pkg::GIDX_W-1:0]        next_gi;
   logic [i2w_pkg::GIDX_W-1:0]        top_gi;
   logic [i2w_pkg::WORD_W-1:0]        tok_word;
   logic                              tok_last;
   logic                              adv;
   logic                              load;

   assign h    = entry_ff.hund[gi_ff];
   assign r    = entry_ff.rest[gi_ff];
   assign tens = i2w_pkg::tens_digit(r);
   assign ones = i2w_pkg::tens_rest(r);

   always_comb begin
      valid_slot[i2w_pkg::SLOT_HUND_DIGIT] = (h != '0);
      valid_slot[i2w_pkg::SLOT_HUND_WORD]  = (h != '0);
      valid_slot[i2w_pkg::SLOT_TENS]       = (r != '0);
      valid_slot[i2w_pkg::SLOT_ONES]       = (r >= i2w_pkg::REST_W'(20)) && (ones != '0);
      valid_slot[i2w_pkg::SLOT_SCALE]      = (gi_ff != i2w_pkg::GRP_UNIT);
   end

   always_comb begin
      cur   = '0;
      found = 1'b0;
      more  = 1'b0;
      for (int i = 0; i < i2w_pkg::SLOTS; i++) begin
         avail[i] = valid_slot[i] && (i2w_pkg::SLOT_W'(i) >= slot_ff);
         if (avail[i]) begin
            if (!found) begin
               cur   = i2w_pkg::SLOT_W'(i);
               found = 1'b1;
            end else begin
               more = 1'b1;
            end
         end
      end
   end

   always_comb begin
      next_gi = '0;
      top_gi  = '0;
      for (int g = 0; g < i2w_pkg::GROUPS; g++) begin
         lower_nz[g] = entry_ff.nz[g] && (i2w_pkg::GIDX_W'(g) < gi_ff);
         if (lower_nz[g]) next_gi = i2w_pkg::GIDX_W'(g);
         if (pop_entry.nz[g]) top_gi = i2w_pkg::GIDX_W'(g);
      end
   end

   always_comb begin
      case (cur)
         i2w_pkg::SLOT_HUND_DIGIT: tok_word = i2w_pkg::WORD_W'(h);
         i2w_pkg::SLOT_HUND_WORD:  tok_word = i2w_pkg::WORD_HUNDRED;
         i2w_pkg::SLOT_TENS: begin
            tok_word = (r < i2w_pkg::REST_W'(20)) ? i2w_pkg::WORD_W'(r) :
                       i2w_pkg::TENS_BASE + i2w_pkg::WORD_W'(tens);
         end
         i2w_pkg::SLOT_ONES:       tok_word = i2w_pkg::WORD_W'(ones);
         i2w_pkg::SLOT_SCALE: begin
            case (gi_ff)
               i2w_pkg::GRP_THOUSAND: tok_word = i2w_pkg::WORD_THOUSAND;
               i2w_pkg::GRP_MILLION:  tok_word = i2w_pkg::WORD_MILLION;
               i2w_pkg::GRP_BILLION:  tok_word = i2w_pkg::WORD_BILLION;
               default:               tok_word = i2w_pkg::WORD_ZERO;
            endcase
         end
         default:                  tok_word = i2w_pkg::WORD_ZERO;
      endcase
      if (entry_ff.zero) tok_word = i2w_pkg::WORD_ZERO;
   end

   assign tok_last  = entry_ff.zero || (!more && (lower_nz == '0));
   assign adv       = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !busy_ff || (adv && tok_last);
   assign load      = pop_valid && pop_ready;

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      entry_in     = entry_ff;
      gi_in        = gi_ff;
      slot_in      = slot_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = tok_word;
         rsp_last_in  = tok_last;
         if (tok_last) begin
            busy_in = 1'b0;
         end else if (more) begin
            slot_in = cur + 1'b1;
         end else begin
            gi_in   = next_gi;
            slot_in = '0;
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         entry_in = pop_entry;
         gi_in    = top_gi;
         slot_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      entry_ff    <= entry_in;
      gi_ff       <= gi_in;
      slot_ff     <= slot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_last  = rsp_last_ff;

   a_group_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !entry_ff.zero |-> entry_ff.nz[gi_ff])
      else $error("walking a zero group");

   a_slot_found: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !entry_ff.zero |-> found)
      else $error("no word left in current group");

endmodule

>>> src/integer_to_word_tokens.sv
// ----------------------------------------------------------------------------
// integer_to_word_tokens: integer to English word token stream
// Names a 31-bit value as word tokens (zero..nineteen, twenty..ninety,
// hundred, thousand, million, billion), one token per transfer, last flagged.
// ----------------------------------------------------------------------------
// The front splits a value with three reciprocal divisions by 1000, each a
// multiply state then a divide state, and a push state hands the split
// groups to a two-entry queue; it takes the next value only in the idle or
// push state. The back emits one token per cycle while the response channel
// does not stall, 1 to 16 tokens per value.
module integer_to_word_tokens (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [i2w_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [i2w_pkg::WORD_W-1:0]    rsp_word,
   output logic                          rsp_last
);

   logic                   push_valid;
   logic                   push_ready;
   i2w_pkg::i2w_entry_type push_entry;
   logic                   pop_valid;
   logic                   pop_ready;
   i2w_pkg::i2w_entry_type pop_entry;

   i2w_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   i2w_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   i2w_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .rsp_last   (rsp_last)
   );

endmodule

>>> tb/tb_integer_to_word_tokens.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_word_tokens: self-checking bench for integer_to_word_tokens
// Feeds 31-bit values over the request channel. Each accepted value is spelled
// into its expected word tokens, and every token transfer on the response
// channel is checked in order. Both sides insert random idle cycles, and the
// receiver holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_integer_to_word_tokens;

   typedef struct packed {
      logic [i2w_pkg::WORD_W-1:0] word;
      logic                       last;
   } word_token_type;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [i2w_pkg::VALUE_W-1:0] req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [i2w_pkg::WORD_W-1:0]  rsp_word;
   logic                        rsp_last;

   logic [i2w_pkg::VALUE_W-1:0] value_q[$];
   word_token_type              spoken_q[$];
   logic                        req_fire = 1'b0;
   logic                        rsp_fire = 1'b0;
   int unsigned                 req_gap = 0;
   int unsigned                 rsp_gap = 0;
   int unsigned                 values_taken = 0;
   int unsigned                 tokens_seen = 0;
   int unsigned                 mismatches = 0;
   bit                          no_idle = 1'b0;
   bit                          hold_off = 1'b0;

   integer_to_word_tokens dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_last)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void push_word(input logic [i2w_pkg::WORD_W-1:0] w);
      word_token_type tok;
      tok.word = w;
      tok.last = 1'b0;
      spoken_q = {spoken_q, tok};
   endfunction

   function automatic void spell_group(input int unsigned g);
      int unsigned h;
      int unsigned r;
      h = g / 100;
      r = g % 100;
      if (h != 0) begin
         push_word(i2w_pkg::WORD_W'(h));
         push_word(i2w_pkg::WORD_HUNDRED);
      end
      if (r != 0) begin
         if (r < 20) begin
            push_word(i2w_pkg::WORD_W'(r));
         end else begin
            push_word(i2w_pkg::TENS_BASE + i2w_pkg::WORD_W'(r / 10));
            if (r % 10 != 0) push_word(i2w_pkg::WORD_W'(r % 10));
         end
      end
   endfunction

   function automatic void spell_value(input logic [i2w_pkg::VALUE_W-1:0] value);
      int unsigned v;
      v = 32'(value);
      if (v == 0) begin
         push_word(i2w_pkg::WORD_ZERO);
      end else begin
         if (v / 1000000000 != 0) begin
            spell_group(v / 1000000000);
            push_word(i2w_pkg::WORD_BILLION);
         end
         if ((v / 1000000) % 1000 != 0) begin
            spell_group((v / 1000000) % 1000);
            push_word(i2w_pkg::WORD_MILLION);
         end
         if ((v / 1000) % 1000 != 0) begin
            spell_group((v / 1000) % 1000);
            push_word(i2w_pkg::WORD_THOUSAND);
         end
         spell_group(v % 1000);
      end
      spoken_q[spoken_q.size()-1].last = 1'b1;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned pick_group();
      int unsigned r;
      r = $urandom_range(0, 3);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(0, 19);
      return $urandom_range(0, 999);
   endfunction

   function automatic logic [i2w_pkg::VALUE_W-1:0] random_value();
      longint unsigned v;
      int unsigned     r;
      r = $urandom_range(0, 99);
      if (r < 30) return i2w_pkg::VALUE_W'($urandom());
      if (r < 80) begin
         v = longint'($urandom_range(0, 2)) * 1000000000 + longint'(pick_group()) * 1000000
             + longint'(pick_group()) * 1000 + longint'(pick_group());
         if (v > 64'd2147483647) v = v - 1000000000;
         return i2w_pkg::VALUE_W'(v);
      end
      if (r < 90) return i2w_pkg::VALUE_W'($urandom_range(0, 1000));
      return i2w_pkg::VALUE_W'($urandom_range(999990, 1000010));
   endfunction

   // request side: hold until transfer, then advance after a gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap != 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (value_q.size() != 0) begin
            req_valid <= 1'b1;
            req_value <= value_q.pop_front();
            req_gap   <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side
   always @(negedge clock) begin
      if (reset || hold_off) begin
         rsp_ready <= 1'b0;
      end else if (!rsp_ready || rsp_fire) begin
         if (rsp_gap != 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_gap   <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      word_token_type want;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         rsp_fire <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) begin
            spell_value(req_value);
            values_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (spoken_q.size() == 0) begin
               report_mismatch($sformatf("token %0d: word %0d last %0b with none expected",
                                         tokens_seen, rsp_word, rsp_last));
            end else begin
               want = spoken_q.pop_front();
               if (rsp_word !== want.word)
                  report_mismatch($sformatf("token %0d: word %0d, expected %0d",
                                            tokens_seen, rsp_word, want.word));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("token %0d: last %0b, expected %0b",
                                            tokens_seen, rsp_last, want.last));
            end
            tokens_seen++;
         end
      end
   end

   // toggle stretches with no idling
   initial begin
      forever begin
         repeat ($urandom_range(200, 600)) @(posedge clock);
         no_idle = ~no_idle;
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (values_taken >= 150);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [i2w_pkg::VALUE_W-1:0] directed[] = '{
         31'd0, 31'd1, 31'd12, 31'd19, 31'd20, 31'd21, 31'd99, 31'd100,
         31'd101, 31'd110, 31'd115, 31'd999, 31'd1000, 31'd1001, 31'd100000,
         31'd1000000, 31'd1000000000, 31'd1000000001, 31'd1010001000,
         31'd2000000000, 31'd2100000000, 31'd1777777777, 31'd1234567891,
         31'h5555_5555, 31'h7fff_ffff
      };
      int unsigned waited;
      foreach (directed[i]) value_q = {value_q, directed[i]};
      repeat (450) value_q = {value_q, random_value()};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (value_q.size() != 0 || req_valid) @(posedge clock);
      waited = 0;
      while (spoken_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (30) @(posedge clock);
      if (spoken_q.size() != 0)
         report_mismatch($sformatf("%0d tokens never arrived", spoken_q.size()));
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> sim.f
src/i2w_pkg.sv
src/i2w_front.sv
src/i2w_queue.sv
src/i2w_back.sv
src/integer_to_word_tokens.sv
tb/tb_integer_to_word_tokens.sv
